FILE: design/pfj_pkg.sv
// shared widths, word types and rounding helper for the power-flow jacobian entry block
`default_nettype none

package pfj_pkg;

  localparam int DW  = 32;          // input data width
  localparam int FB  = 24;          // fraction bits
  localparam int OW  = 48;          // result width
  localparam int L   = OW / 2;      // split point of a result for the partial products
  localparam int SW2 = 2 * DW;      // full product of two inputs
  localparam int PW  = OW + DW;     // result times input
  localparam int TW  = PW + 2;      // sum of up to three such products
  localparam int RW  = TW + 2;      // rounding headroom
  localparam int QB  = FB + 2;      // quotient bits of the normalize divide
  localparam int EW  = FB + 2;      // signed unit-vector component

  typedef struct packed {
    logic                 kind;
    logic signed [DW-1:0] y_re;
    logic signed [DW-1:0] y_im;
    logic signed [DW-1:0] vrow_re;
    logic signed [DW-1:0] vrow_im;
    logic signed [DW-1:0] vcol_re;
    logic signed [DW-1:0] vcol_im;
    logic signed [DW-1:0] cur_re;
    logic signed [DW-1:0] cur_im;
    logic [3:0]           present_mask;
  } in_t;

  typedef struct packed {
    logic signed [OW-1:0] angle_real;
    logic signed [OW-1:0] angle_imag;
    logic signed [OW-1:0] mag_real;
    logic signed [OW-1:0] mag_imag;
    logic [3:0]           valid_mask;
    logic                 saturated;
  } out_t;

  // operands that ride alongside the root and divide pipelines
  typedef struct packed {
    logic                 kind;
    logic [3:0]           mask;
    logic signed [DW-1:0] y_re;
    logic signed [DW-1:0] y_im;
    logic signed [DW-1:0] vr_re;
    logic signed [DW-1:0] vr_im;
    logic signed [DW-1:0] cur_re;
    logic signed [DW-1:0] cur_im;
    logic signed [DW-1:0] vj_re;
    logic signed [DW-1:0] vj_im;
    logic signed [OW-1:0] w_re;
    logic signed [OW-1:0] w_im;
    logic                 w_sat;
  } side_t;

  typedef struct packed {
    logic signed [OW-1:0] value;
    logic                 sat;
  } rs_t;

  // round half up to FB fraction bits, clip to OW bits
  function automatic rs_t round_sat(input logic signed [RW-1:0] x);
    logic signed [RW-1:0]    s;
    logic [RW-FB-OW:0]       top;
    rs_t                     r;
    s   = x + $signed({{(RW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}});
    top = s[RW-1:FB+OW-1];
    r.sat = !((&top) || !(|top));
    if (r.sat) begin
      r.value = s[RW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end else begin
      r.value = s[FB+OW-1:FB];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/pfj_isqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none

module pfj_isqrt (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [pfj_pkg::SW2-1:0]  x_i,
  input  pfj_pkg::side_t           side_i,
  output logic                     valid_o,
  output logic [pfj_pkg::DW-1:0]   root_o,
  output pfj_pkg::side_t           side_o
);

  localparam int N   = pfj_pkg::DW;
  localparam int RMW = N + 2;
  localparam int XW  = pfj_pkg::SW2;

  logic                 v_q     [N];
  logic                 v_d     [N];
  logic [RMW-1:0]       rem_q   [N];
  logic [RMW-1:0]       rem_d   [N];
  logic [N-1:0]         root_q  [N];
  logic [N-1:0]         root_d  [N];
  logic [XW-1:0]        x_q     [N];
  logic [XW-1:0]        x_d     [N];
  pfj_pkg::side_t       side_q  [N];
  pfj_pkg::side_t       side_d  [N];

  logic [RMW-1:0]       rin     [N];
  logic [N-1:0]         qin     [N];
  logic [XW-1:0]        xin     [N];

  always_comb begin
    rin[0]    = '0;
    qin[0]    = '0;
    xin[0]    = x_i;
    v_d[0]    = valid_i;
    side_d[0] = side_i;
    for (int k = 1; k < N; k++) begin
      rin[k]    = rem_q[k-1];
      qin[k]    = root_q[k-1];
      xin[k]    = x_q[k-1];
      v_d[k]    = v_q[k-1];
      side_d[k] = side_q[k-1];
    end
  end

  // restoring recurrence: bring down two radicand bits, try root*4+1
  always_comb begin
    logic [RMW-1:0] rsh;
    logic [RMW-1:0] trial;
    rsh   = '0;
    trial = '0;
    for (int k = 0; k < N; k++) begin
      rsh   = {rin[k][RMW-3:0], xin[k][XW-1 -: 2]};
      trial = {qin[k], 2'b01};
      if (rsh >= trial) begin
        rem_d[k]  = rsh - trial;
        root_d[k] = {qin[k][N-2:0], 1'b1};
      end else begin
        rem_d[k]  = rsh;
        root_d[k] = {qin[k][N-2:0], 1'b0};
      end
      x_d[k] = {xin[k][XW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < N; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        x_q[k]    <= x_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

FILE: design/pfj_div.sv
// pipelined restoring divide of both voltage components by the magnitude
`default_nettype none

module pfj_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [pfj_pkg::DW-1:0]  m_i,
  input  pfj_pkg::side_t          side_i,
  output logic                    valid_o,
  output logic [pfj_pkg::QB-1:0]  qr_o,
  output logic [pfj_pkg::QB-1:0]  qi_o,
  output pfj_pkg::side_t          side_o
);

  localparam int N  = pfj_pkg::QB;
  localparam int DW = pfj_pkg::DW;

  logic              v_q    [N];
  logic              v_d    [N];
  logic [DW-1:0]     rr_q   [N];
  logic [DW-1:0]     rr_d   [N];
  logic [DW-1:0]     ri_q   [N];
  logic [DW-1:0]     ri_d   [N];
  logic [N-1:0]      qr_q   [N];
  logic [N-1:0]      qr_d   [N];
  logic [N-1:0]      qi_q   [N];
  logic [N-1:0]      qi_d   [N];
  logic [DW-1:0]     m_q    [N];
  pfj_pkg::side_t    side_q [N];
  pfj_pkg::side_t    side_d [N];

  logic [DW-1:0]     rin_r  [N];
  logic [DW-1:0]     rin_i  [N];
  logic              bin_r  [N];
  logic              bin_i  [N];
  logic [N-1:0]      qin_r  [N];
  logic [N-1:0]      qin_i  [N];
  logic [DW-1:0]     min    [N];

  logic [DW-1:0]     mag_r;
  logic [DW-1:0]     mag_i;

  assign mag_r = side_i.vj_re[DW-1] ? (~side_i.vj_re + 1'b1) : side_i.vj_re;
  assign mag_i = side_i.vj_im[DW-1] ? (~side_i.vj_im + 1'b1) : side_i.vj_im;

  // numerator is |v| << (FB+1); its top part is |v| >> 1, then bit 0 of |v|, then zeros
  always_comb begin
    rin_r[0]  = mag_r >> 1;
    rin_i[0]  = mag_i >> 1;
    bin_r[0]  = mag_r[0];
    bin_i[0]  = mag_i[0];
    qin_r[0]  = '0;
    qin_i[0]  = '0;
    min[0]    = (m_i == '0) ? DW'(1) : m_i;
    v_d[0]    = valid_i;
    side_d[0] = side_i;
    for (int k = 1; k < N; k++) begin
      rin_r[k]  = rr_q[k-1];
      rin_i[k]  = ri_q[k-1];
      bin_r[k]  = 1'b0;
      bin_i[k]  = 1'b0;
      qin_r[k]  = qr_q[k-1];
      qin_i[k]  = qi_q[k-1];
      min[k]    = m_q[k-1];
      v_d[k]    = v_q[k-1];
      side_d[k] = side_q[k-1];
    end
  end

  always_comb begin
    logic [DW:0] sr;
    logic [DW:0] si;
    logic [DW:0] dr;
    logic [DW:0] di;
    sr = '0;
    si = '0;
    dr = '0;
    di = '0;
    for (int k = 0; k < N; k++) begin
      sr = {rin_r[k], bin_r[k]};
      si = {rin_i[k], bin_i[k]};
      dr = sr - {1'b0, min[k]};
      di = si - {1'b0, min[k]};
      if (sr >= {1'b0, min[k]}) begin
        rr_d[k] = dr[DW-1:0];
        qr_d[k] = {qin_r[k][N-2:0], 1'b1};
      end else begin
        rr_d[k] = sr[DW-1:0];
        qr_d[k] = {qin_r[k][N-2:0], 1'b0};
      end
      if (si >= {1'b0, min[k]}) begin
        ri_d[k] = di[DW-1:0];
        qi_d[k] = {qin_i[k][N-2:0], 1'b1};
      end else begin
        ri_d[k] = si[DW-1:0];
        qi_d[k] = {qin_i[k][N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < N; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < N; k++) begin
        rr_q[k]   <= rr_d[k];
        ri_q[k]   <= ri_d[k];
        qr_q[k]   <= qr_d[k];
        qi_q[k]   <= qi_d[k];
        m_q[k]    <= min[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign qr_o    = qr_q[N-1];
  assign qi_o    = qi_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

`default_nettype wire

FILE: design/power_flow_jacobian_entry.sv
// top level: polar newton power-flow jacobian values for one admittance entry
// One word enters per clock and one result word leaves per clock while the output is not
// stalled. The word passes 68 register stages: the input register, the 32-stage square
// root (one root bit per stage), the 26-stage normalize divide (one quotient bit per stage)
// and nine stages of multiply, sum and rounding, the last of them the output register. All
// stages before the output register share one advance enable; a two-entry output buffer
// lets the input keep accepting while a result waits.
`default_nettype none

module power_flow_jacobian_entry (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pfj_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pfj_pkg::out_t  out_data_o
);

  localparam int DW  = pfj_pkg::DW;
  localparam int OW  = pfj_pkg::OW;
  localparam int L   = pfj_pkg::L;
  localparam int SW2 = pfj_pkg::SW2;
  localparam int PW  = pfj_pkg::PW;
  localparam int TW  = pfj_pkg::TW;
  localparam int RW  = pfj_pkg::RW;
  localparam int QB  = pfj_pkg::QB;
  localparam int EW  = pfj_pkg::EW;
  localparam int CW  = SW2 + 1;       // sum of two input products
  localparam int NW  = DW + EW;       // input times unit component
  localparam int MW  = NW + 1;

  logic en;
  logic skid_v_q;
  logic out_v_q;
  pfj_pkg::out_t out_q;
  pfj_pkg::out_t skid_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // ---------------- input register
  logic          v1_q;
  pfj_pkg::in_t  in1_q;

  // ---------------- first products
  logic                   v2_q;
  pfj_pkg::in_t           in2_q;
  logic signed [DW-1:0]   jr_c, ji_c, jr2_q, ji2_q;
  logic signed [SW2-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q, q_rr_q, q_ii_q;

  assign jr_c = in1_q.kind ? in1_q.vrow_re : in1_q.vcol_re;
  assign ji_c = in1_q.kind ? in1_q.vrow_im : in1_q.vcol_im;

  // ---------------- w and squared magnitude
  logic             v3_q;
  pfj_pkg::side_t   side3_d, side3_q;
  logic [SW2-1:0]   mag2_q;
  pfj_pkg::rs_t     wr_c, wi_c;

  assign wr_c = pfj_pkg::round_sat(RW'(p_rr_q) - RW'(p_ii_q));
  assign wi_c = pfj_pkg::round_sat(RW'(p_ri_q) + RW'(p_ir_q));

  always_comb begin
    side3_d.kind   = in2_q.kind;
    side3_d.mask   = in2_q.present_mask;
    side3_d.y_re   = in2_q.y_re;
    side3_d.y_im   = in2_q.y_im;
    side3_d.vr_re  = in2_q.vrow_re;
    side3_d.vr_im  = in2_q.vrow_im;
    side3_d.cur_re = in2_q.cur_re;
    side3_d.cur_im = in2_q.cur_im;
    side3_d.vj_re  = jr2_q;
    side3_d.vj_im  = ji2_q;
    side3_d.w_re   = wr_c.value;
    side3_d.w_im   = wi_c.value;
    side3_d.w_sat  = wr_c.sat | wi_c.sat;
  end

  // ---------------- root and divide
  logic             v_sq;
  logic [DW-1:0]    m_sq;
  pfj_pkg::side_t   side_sq;
  logic             v_dv;
  logic [QB-1:0]    qr_dv, qi_dv;
  pfj_pkg::side_t   side_dv;

  pfj_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .x_i     (mag2_q),
    .side_i  (side3_q),
    .valid_o (v_sq),
    .root_o  (m_sq),
    .side_o  (side_sq)
  );

  pfj_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v_sq),
    .m_i     (m_sq),
    .side_i  (side_sq),
    .valid_o (v_dv),
    .qr_o    (qr_dv),
    .qi_o    (qi_dv),
    .side_o  (side_dv)
  );

  // ---------------- unit vector: round the quotient half away from zero
  logic                 v4_q;
  pfj_pkg::side_t       side4_q;
  logic signed [EW-1:0] er_q, ei_q, er_d, ei_d;
  logic [QB:0]          qr_inc, qi_inc;
  logic signed [EW-1:0] er_mag, ei_mag;

  assign qr_inc = {1'b0, qr_dv} + 1'b1;
  assign qi_inc = {1'b0, qi_dv} + 1'b1;
  assign er_mag = $signed({1'b0, qr_inc[QB-1:1]});
  assign ei_mag = $signed({1'b0, qi_inc[QB-1:1]});
  assign er_d   = side_dv.vj_re[DW-1] ? -er_mag : er_mag;
  assign ei_d   = side_dv.vj_im[DW-1] ? -ei_mag : ei_mag;

  // ---------------- M1: products
  logic                  v5_q;
  pfj_pkg::side_t        side5_q;
  logic signed [NW-1:0]  yrer_q, yiei_q, yrei_q, yier_q, cer_q, dei_q, cei_q, der_q;
  logic signed [SW2-1:0] bc_q, ad_q, ac_q, bd_q;
  logic signed [DW+L:0]  awrl_q, awil_q, bwrl_q, bwil_q;
  logic signed [DW+L-1:0] awrh_q, awih_q, bwrh_q, bwih_q;
  logic signed [L:0]     wrl_c, wil_c;
  logic signed [L-1:0]   wrh_c, wih_c;

  assign wrl_c = $signed({1'b0, side4_q.w_re[L-1:0]});
  assign wil_c = $signed({1'b0, side4_q.w_im[L-1:0]});
  assign wrh_c = $signed(side4_q.w_re[OW-1:L]);
  assign wih_c = $signed(side4_q.w_im[OW-1:L]);

  // ---------------- M2: n, w products combined, current terms
  logic                  v6_q;
  pfj_pkg::side_t        side6_q;
  logic signed [PW-1:0]  awr_q, awi_q, bwr_q, bwi_q;
  logic signed [CW-1:0]  cv0_q, cv1_q;
  logic signed [MW-1:0]  cm2_q, cm3_q;
  logic signed [OW-1:0]  nr_q, ni_q;
  logic                  sn6_q;
  pfj_pkg::rs_t          nr_c, ni_c;

  assign nr_c = pfj_pkg::round_sat(RW'(yrer_q) - RW'(yiei_q));
  assign ni_c = pfj_pkg::round_sat(RW'(yrei_q) + RW'(yier_q));

  // ---------------- M3: angle sums, n partial products
  logic                   v7_q;
  pfj_pkg::side_t         side7_q;
  logic                   sn7_q;
  logic signed [TW-1:0]   t0_q, t1_q;
  logic signed [MW-1:0]   cm2b_q, cm3b_q;
  logic signed [DW+L:0]   anrl_q, anil_q, bnrl_q, bnil_q;
  logic signed [DW+L-1:0] anrh_q, anih_q, bnrh_q, bnih_q;
  logic signed [L:0]      nrl_c, nil_c;
  logic signed [L-1:0]    nrh_c, nih_c;

  assign nrl_c = $signed({1'b0, nr_q[L-1:0]});
  assign nil_c = $signed({1'b0, ni_q[L-1:0]});
  assign nrh_c = $signed(nr_q[OW-1:L]);
  assign nih_c = $signed(ni_q[OW-1:L]);

  // ---------------- M4: n products combined
  logic                  v8_q;
  logic [3:0]            mask8_q;
  logic                  sw8_q, sn8_q;
  logic signed [TW-1:0]  t0b_q, t1b_q;
  logic signed [MW-1:0]  cm2c_q, cm3c_q;
  logic signed [PW-1:0]  anr_q, ani_q, bnr_q, bni_q;

  // ---------------- M5: magnitude sums
  logic                  v9_q;
  logic [3:0]            mask9_q;
  logic                  sw9_q, sn9_q;
  logic signed [TW-1:0]  t0c_q, t1c_q, t2_q, t3_q;

  // ---------------- final rounding into the output buffer
  pfj_pkg::rs_t   r0_c, r1_c, r2_c, r3_c;
  pfj_pkg::out_t  res_c;
  logic           push, pop;

  assign r0_c = pfj_pkg::round_sat(RW'(t0c_q));
  assign r1_c = pfj_pkg::round_sat(RW'(t1c_q));
  assign r2_c = pfj_pkg::round_sat(RW'(t2_q));
  assign r3_c = pfj_pkg::round_sat(RW'(t3_q));

  always_comb begin
    res_c.angle_real = mask9_q[0] ? r0_c.value : '0;
    res_c.angle_imag = mask9_q[1] ? r1_c.value : '0;
    res_c.mag_real   = mask9_q[2] ? r2_c.value : '0;
    res_c.mag_imag   = mask9_q[3] ? r3_c.value : '0;
    res_c.valid_mask = mask9_q;
    res_c.saturated  = (mask9_q[0] & (r0_c.sat | sw9_q)) |
                       (mask9_q[1] & (r1_c.sat | sw9_q)) |
                       (mask9_q[2] & (r2_c.sat | sn9_q)) |
                       (mask9_q[3] & (r3_c.sat | sn9_q));
  end

  assign push = en & v9_q;
  assign pop  = out_v_q & out_ready_i;

  // ---------------- valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v_dv;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  // ---------------- datapath registers
  always_ff @(posedge clk_i) begin
    if (en) begin
      in1_q   <= in_data_i;

      in2_q   <= in1_q;
      jr2_q   <= jr_c;
      ji2_q   <= ji_c;
      p_rr_q  <= in1_q.y_re * jr_c;
      p_ii_q  <= in1_q.y_im * ji_c;
      p_ri_q  <= in1_q.y_re * ji_c;
      p_ir_q  <= in1_q.y_im * jr_c;
      q_rr_q  <= jr_c * jr_c;
      q_ii_q  <= ji_c * ji_c;

      side3_q <= side3_d;
      mag2_q  <= $unsigned(q_rr_q) + $unsigned(q_ii_q);

      side4_q <= side_dv;
      er_q    <= er_d;
      ei_q    <= ei_d;

      side5_q <= side4_q;
      yrer_q  <= side4_q.y_re * er_q;
      yiei_q  <= side4_q.y_im * ei_q;
      yrei_q  <= side4_q.y_re * ei_q;
      yier_q  <= side4_q.y_im * er_q;
      cer_q   <= side4_q.cur_re * er_q;
      dei_q   <= side4_q.cur_im * ei_q;
      cei_q   <= side4_q.cur_re * ei_q;
      der_q   <= side4_q.cur_im * er_q;
      bc_q    <= side4_q.vr_im * side4_q.cur_re;
      ad_q    <= side4_q.vr_re * side4_q.cur_im;
      ac_q    <= side4_q.vr_re * side4_q.cur_re;
      bd_q    <= side4_q.vr_im * side4_q.cur_im;
      awrl_q  <= side4_q.vr_re * wrl_c;
      awrh_q  <= side4_q.vr_re * wrh_c;
      awil_q  <= side4_q.vr_re * wil_c;
      awih_q  <= side4_q.vr_re * wih_c;
      bwrl_q  <= side4_q.vr_im * wrl_c;
      bwrh_q  <= side4_q.vr_im * wrh_c;
      bwil_q  <= side4_q.vr_im * wil_c;
      bwih_q  <= side4_q.vr_im * wih_c;

      side6_q <= side5_q;
      awr_q   <= (PW'(awrh_q) <<< L) + PW'(awrl_q);
      awi_q   <= (PW'(awih_q) <<< L) + PW'(awil_q);
      bwr_q   <= (PW'(bwrh_q) <<< L) + PW'(bwrl_q);
      bwi_q   <= (PW'(bwih_q) <<< L) + PW'(bwil_q);
      // bus current terms only on a diagonal word
      cv0_q   <= side5_q.kind ? (CW'(bc_q) - CW'(ad_q)) : '0;
      cv1_q   <= side5_q.kind ? (CW'(ac_q) + CW'(bd_q)) : '0;
      cm2_q   <= side5_q.kind ? (MW'(cer_q) + MW'(dei_q)) : '0;
      cm3_q   <= side5_q.kind ? (MW'(cei_q) - MW'(der_q)) : '0;
      nr_q    <= nr_c.value;
      ni_q    <= ni_c.value;
      sn6_q   <= nr_c.sat | ni_c.sat;

      side7_q <= side6_q;
      sn7_q   <= sn6_q;
      t0_q    <= TW'(bwr_q) - TW'(awi_q) - TW'(cv0_q);
      t1_q    <= TW'(cv1_q) - TW'(awr_q) - TW'(bwi_q);
      cm2b_q  <= cm2_q;
      cm3b_q  <= cm3_q;
      anrl_q  <= side6_q.vr_re * nrl_c;
      anrh_q  <= side6_q.vr_re * nrh_c;
      anil_q  <= side6_q.vr_re * nil_c;
      anih_q  <= side6_q.vr_re * nih_c;
      bnrl_q  <= side6_q.vr_im * nrl_c;
      bnrh_q  <= side6_q.vr_im * nrh_c;
      bnil_q  <= side6_q.vr_im * nil_c;
      bnih_q  <= side6_q.vr_im * nih_c;

      mask8_q <= side7_q.mask;
      sw8_q   <= side7_q.w_sat;
      sn8_q   <= sn7_q;
      t0b_q   <= t0_q;
      t1b_q   <= t1_q;
      cm2c_q  <= cm2b_q;
      cm3c_q  <= cm3b_q;
      anr_q   <= (PW'(anrh_q) <<< L) + PW'(anrl_q);
      ani_q   <= (PW'(anih_q) <<< L) + PW'(anil_q);
      bnr_q   <= (PW'(bnrh_q) <<< L) + PW'(bnrl_q);
      bni_q   <= (PW'(bnih_q) <<< L) + PW'(bnil_q);

      mask9_q <= mask8_q;
      sw9_q   <= sw8_q;
      sn9_q   <= sn8_q;
      t0c_q   <= t0b_q;
      t1c_q   <= t1b_q;
      t2_q    <= TW'(anr_q) + TW'(bni_q) + TW'(cm2c_q);
      t3_q    <= TW'(bnr_q) - TW'(ani_q) + TW'(cm3c_q);
    end
  end

  // ---------------- output register plus skid word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_v_q && !pop) begin
        skid_q <= res_c;
      end else begin
        out_q <= res_c;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // ---------------- checks
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word held without an output word");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !out_ready_i) |=> !in_ready_o)
    else $error("input taken while both output words are full");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !skid_v_q && !push && out_ready_i) |=> !out_v_q)
    else $error("output word kept after it was taken");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> ((out_q.valid_mask[0] || out_q.angle_real == '0) &&
                 (out_q.valid_mask[1] || out_q.angle_imag == '0) &&
                 (out_q.valid_mask[2] || out_q.mag_real == '0) &&
                 (out_q.valid_mask[3] || out_q.mag_imag == '0)))
    else $error("absent sub-block carries a value");

endmodule

`default_nettype wire
